>>> hw/rtl/adpcm4_pkg.sv
`timescale 1ns / 1ps

package adpcm4_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned PosW    = 6;
  localparam int unsigned StepW   = 11;
  localparam int unsigned NumSteps = 49;

  localparam logic [PosW-1:0]     MaxPos    = 6'd48;
  localparam logic signed [13:0]  SampleMax = 14'sd2047;
  localparam logic signed [13:0]  SampleMin = -14'sd2048;

  localparam logic [StepW-1:0] StepTable [NumSteps] = '{
    11'd16,   11'd17,   11'd19,   11'd21,   11'd23,   11'd25,   11'd28,
    11'd31,   11'd34,   11'd37,   11'd41,   11'd45,   11'd50,   11'd55,
    11'd60,   11'd66,   11'd73,   11'd80,   11'd88,   11'd97,   11'd107,
    11'd118,  11'd130,  11'd143,  11'd157,  11'd173,  11'd190,  11'd209,
    11'd230,  11'd253,  11'd279,  11'd307,  11'd337,  11'd371,  11'd408,
    11'd449,  11'd494,  11'd544,  11'd598,  11'd658,  11'd724,  11'd796,
    11'd876,  11'd963,  11'd1060, 11'd1166, 11'd1282, 11'd1411, 11'd1552
  };

  typedef struct packed {
    logic [SampleW-1:0] predictor;
    logic [PosW-1:0]    step_pos;
  } dec_state_t;

endpackage

>>> hw/rtl/adpcm4_nibble.sv
`timescale 1ns / 1ps

module adpcm4_nibble (
  input  adpcm4_pkg::dec_state_t state_i,
  input  logic [3:0]             code_i,
  output adpcm4_pkg::dec_state_t state_o
);
  import adpcm4_pkg::*;

  logic [PosW-1:0]      pos_lim;
  logic [SampleW-1:0]   step_w;
  logic [SampleW-1:0]   delta;
  logic signed [13:0]   delta_s;
  logic signed [13:0]   sum;
  logic [PosW:0]        pos_up;

  always_comb begin
    pos_lim = (state_i.step_pos > MaxPos) ? MaxPos : state_i.step_pos;
    step_w  = {1'b0, StepTable[pos_lim]};

    delta = step_w >> 3;
    if (code_i[0]) delta = delta + (step_w >> 2);
    if (code_i[1]) delta = delta + (step_w >> 1);
    if (code_i[2]) delta = delta + step_w;

    delta_s = code_i[3] ? -$signed({2'b00, delta}) : $signed({2'b00, delta});
    sum     = $signed({{2{state_i.predictor[SampleW-1]}}, state_i.predictor}) + delta_s;

    priority if (sum > SampleMax) begin
      state_o.predictor = SampleMax[SampleW-1:0];
    end else if (sum < SampleMin) begin
      state_o.predictor = SampleMin[SampleW-1:0];
    end else begin
      state_o.predictor = sum[SampleW-1:0];
    end

    // small magnitudes walk down by one, large ones up by 2, 4, 6 or 8
    pos_up = {1'b0, pos_lim} + {4'd0, code_i[1:0], 1'b0} + 7'd2;
    if (!code_i[2]) begin
      state_o.step_pos = (pos_lim == '0) ? '0 : pos_lim - 6'd1;
    end else begin
      state_o.step_pos = (pos_up > {1'b0, MaxPos}) ? MaxPos : pos_up[PosW-1:0];
    end
  end

endmodule

>>> hw/rtl/adpcm_4bit_stream_decoder.sv
`timescale 1ns / 1ps

// 4-bit ADPCM stream decoder.
// Input channel: one beat carries code_byte_i, two packed 4-bit codes.
// Output channel: one beat per decoded 12-bit signed sample (Q1.11); the
// low nibble's sample comes first with last_of_pair_o = 0, then the high
// nibble's with last_of_pair_o = 1.
// Both channels move a beat when valid is high and stall is low.
// The low sample is decoded from the byte register and offered from the output
// register; the high sample follows once the decoder advances again. The
// single nibble decoder is shared by both codes of a byte and
// carries predictor and step position from one code to the next.
// The next byte is taken in the cycle the high nibble is decoded, while the
// previous sample may still sit in the output register.
// A stall on the output holds the output register and the decoder; the
// input then stalls once its byte register is full.
// Reset clears predictor and step position to zero and drops all beats.
module adpcm_4bit_stream_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   code_byte_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [11:0]  sample_o,
  output logic         last_of_pair_o
);
  import adpcm4_pkg::*;

  logic               in_valid_q, in_valid_d;
  logic               half_q, half_d;
  logic [7:0]         byte_q;
  logic               out_valid_q, out_valid_d;
  logic [SampleW-1:0] sample_q;
  logic               last_q;
  dec_state_t         state_q, state_d;
  logic [3:0]         code;
  logic               advance;
  logic               in_take;

  adpcm4_nibble u_nibble (
    .state_i (state_q),
    .code_i  (code),
    .state_o (state_d)
  );

  assign code       = half_q ? byte_q[7:4] : byte_q[3:0];
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !(advance && half_q);
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    half_d     = half_q;
    if (advance) begin
      half_d = !half_q;
      if (half_q) in_valid_d = 1'b0;
    end
    if (in_take) begin
      in_valid_d = 1'b1;
      half_d     = 1'b0;
    end
    out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
      if (advance) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) byte_q <= code_byte_i;
    if (advance) begin
      sample_q <= state_d.predictor;
      last_q   <= half_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign last_of_pair_o = last_q;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.step_pos <= MaxPos)
    else $error("step position left table range");

  a_take_starts_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q && !half_q)
    else $error("new byte did not start with low nibble");

  a_low_then_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !half_q |=> in_valid_q && half_q && out_valid_o && !last_of_pair_o)
    else $error("low nibble not followed by high nibble");

  a_no_take_on_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !half_q |-> in_stall_o)
    else $error("byte taken while low nibble pending");
`endif

endmodule
